@@ rtl/refract_vector_3d_unit_assert.svh @@
// Assertion macros used by the refraction unit checker
`ifndef REFRACT_VECTOR_3D_UNIT_ASSERT_SVH
`define REFRACT_VECTOR_3D_UNIT_ASSERT_SVH

// same-cycle implication
`define REFV_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("refv assertion failed");

// next-cycle implication
`define REFV_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("refv assertion failed");

`endif

@@ rtl/refv_pkg.sv @@
// Types, constants and rounding helper for the refraction unit
package refv_pkg;

  localparam int FRAC_BITS    = 14;
  localparam int IN_W         = 16;
  localparam int OUT_W        = 18;
  localparam int RND_W        = 48;
  localparam int D_W          = 19;
  localparam int E2_W         = 19;
  localparam int OMD_W        = 24;
  localparam int K_W          = 28;
  localparam int S_W          = 20;
  localparam int RAD_W        = 2 * S_W;
  localparam int REM_W        = S_W + 2;
  localparam int ED_W         = 22;
  localparam int M_W          = 23;
  localparam int R_W          = 26;
  localparam int FRONT_STAGES = 7;
  localparam int BACK_STAGES  = 4;
  localparam int LATENCY      = FRONT_STAGES + S_W + BACK_STAGES;

  localparam logic [RND_W-1:0]        HALF    = RND_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [RND_W-1:0] ONE     = RND_W'(1) << FRAC_BITS;
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic signed [IN_W-1:0] ix;
    logic signed [IN_W-1:0] iy;
    logic signed [IN_W-1:0] iz;
    logic signed [IN_W-1:0] nx;
    logic signed [IN_W-1:0] ny;
    logic signed [IN_W-1:0] nz;
    logic [IN_W-1:0]        eta;
  } refv_item_t;

  typedef struct packed {
    refv_item_t             item;
    logic signed [ED_W-1:0] ed;
    logic                   tr;
    logic [RAD_W-1:0]       rad;
  } refv_mid_t;

  typedef struct packed {
    refv_item_t             item;
    logic signed [ED_W-1:0] ed;
    logic                   tr;
    logic [S_W-1:0]         s;
  } refv_root_t;

  // x / 2^FRAC_BITS, rounded to nearest, ties away from zero
  function automatic logic signed [RND_W-1:0] rnd_frac(input logic signed [RND_W-1:0] x);
    logic [RND_W-1:0] mag;
    logic [RND_W-1:0] q;
    mag = x[RND_W-1] ? RND_W'(-x) : RND_W'(x);
    q = (mag + HALF) >> FRAC_BITS;
    rnd_frac = x[RND_W-1] ? $signed(-q) : $signed(q);
  endfunction

endpackage

@@ rtl/refv_front.sv @@
// Front pipeline: dot product, eta squared and k = 1 - eta^2 (1 - d^2)
module refv_front import refv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  refv_item_t in_item,
  output logic       mid_valid,
  output refv_mid_t  mid
);

  logic [FRONT_STAGES-1:0] v_r;
  refv_item_t item_r [FRONT_STAGES];

  logic signed [2*IN_W-1:0]        p_r [3];
  logic signed [2*IN_W-1:0]        p_nxt [3];
  logic [2*IN_W-1:0]               ee_r, ee_nxt;
  logic signed [2*IN_W+1:0]        dot_r, dot_nxt;
  logic [E2_W-1:0]                 e2a_r, e2b_r, e2c_r, e2d_r, e2_nxt;
  logic signed [D_W-1:0]           d_r, d_nxt;
  logic signed [2*D_W-1:0]         dsq_r, dsq_nxt;
  logic signed [IN_W+D_W:0]        edp_r, edp_nxt;
  logic signed [OMD_W-1:0]         omd_r, omd_nxt;
  logic signed [ED_W-1:0]          ed5_r, ed6_r, ed7_r, ed_nxt;
  logic signed [E2_W+OMD_W:0]      kp_r, kp_nxt;
  logic signed [K_W-1:0]           k_r, k_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[FRONT_STAGES-2:0], in_valid};
    end
  end

  always_comb begin
    p_nxt[0] = in_item.nx * in_item.ix;
    p_nxt[1] = in_item.ny * in_item.iy;
    p_nxt[2] = in_item.nz * in_item.iz;
    ee_nxt   = in_item.eta * in_item.eta;
    dot_nxt  = (2*IN_W+2)'(p_r[0]) + (2*IN_W+2)'(p_r[1]) + (2*IN_W+2)'(p_r[2]);
    e2_nxt   = E2_W'((RND_W'(ee_r) + HALF) >> FRAC_BITS);
    d_nxt    = D_W'(rnd_frac(RND_W'(dot_r)));
    dsq_nxt  = d_r * d_r;
    edp_nxt  = $signed({1'b0, item_r[2].eta}) * d_r;
    omd_nxt  = OMD_W'(ONE - rnd_frac(RND_W'(dsq_r)));
    ed_nxt   = ED_W'(rnd_frac(RND_W'(edp_r)));
    kp_nxt   = $signed({1'b0, e2d_r}) * omd_r;
    k_nxt    = K_W'(ONE - rnd_frac(RND_W'(kp_r)));
  end

  always_ff @(posedge clk) begin
    item_r[0] <= in_item;
    for (int s = 1; s < FRONT_STAGES; s++) begin
      item_r[s] <= item_r[s-1];
    end
    p_r   <= p_nxt;
    ee_r  <= ee_nxt;
    dot_r <= dot_nxt;
    e2a_r <= e2_nxt;
    d_r   <= d_nxt;
    e2b_r <= e2a_r;
    dsq_r <= dsq_nxt;
    edp_r <= edp_nxt;
    e2c_r <= e2b_r;
    omd_r <= omd_nxt;
    ed5_r <= ed_nxt;
    e2d_r <= e2c_r;
    kp_r  <= kp_nxt;
    ed6_r <= ed5_r;
    k_r   <= k_nxt;
    ed7_r <= ed6_r;
  end

  assign mid_valid = v_r[FRONT_STAGES-1];
  assign mid.item  = item_r[FRONT_STAGES-1];
  assign mid.ed    = ed7_r;
  assign mid.tr    = k_r[K_W-1];
  assign mid.rad   = k_r[K_W-1] ? '0 :
                     {k_r[RAD_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};

endmodule

@@ rtl/refv_sqrt.sv @@
// Integer square root, one result bit per pipeline stage
module refv_sqrt import refv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       mid_valid,
  input  refv_mid_t  mid,
  output logic       root_valid,
  output refv_root_t root
);

  logic [S_W-1:0]   v_r;
  refv_mid_t        side_r [S_W];
  logic [REM_W-1:0] rem_r  [S_W];
  logic [S_W-1:0]   q_r    [S_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[S_W-2:0], mid_valid};
    end
  end

  for (genvar t = 0; t < S_W; t++) begin : g_step
    refv_mid_t        side_in, side_nxt;
    logic [REM_W-1:0] rem_in, rem_nxt;
    logic [S_W-1:0]   q_in, q_nxt;
    logic [REM_W+1:0] cur, trial;

    if (t == 0) begin : g_first
      assign side_in = mid;
      assign rem_in  = '0;
      assign q_in    = '0;
    end else begin : g_next
      assign side_in = side_r[t-1];
      assign rem_in  = rem_r[t-1];
      assign q_in    = q_r[t-1];
    end

    always_comb begin
      side_nxt     = side_in;
      side_nxt.rad = side_in.rad << 2;
      cur          = {rem_in, side_in.rad[RAD_W-1 -: 2]};
      trial        = (REM_W+2)'({q_in, 2'b01});
      if (cur >= trial) begin
        rem_nxt = REM_W'(cur - trial);
        q_nxt   = {q_in[S_W-2:0], 1'b1};
      end else begin
        rem_nxt = REM_W'(cur);
        q_nxt   = {q_in[S_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      side_r[t] <= side_nxt;
      rem_r[t]  <= rem_nxt;
      q_r[t]    <= q_nxt;
    end
  end

  assign root_valid = v_r[S_W-1];
  assign root.item  = side_r[S_W-1].item;
  assign root.ed    = side_r[S_W-1].ed;
  assign root.tr    = side_r[S_W-1].tr;
  assign root.s     = q_r[S_W-1];

endmodule

@@ rtl/refv_back.sv @@
// Back pipeline: m = eta d + sqrt(k), eta i - n m, saturation, result register
module refv_back import refv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    root_valid,
  input  refv_root_t              root,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_x,
  output logic signed [OUT_W-1:0] out_y,
  output logic signed [OUT_W-1:0] out_z,
  output logic                    out_tr,
  output logic                    out_sat
);

  logic [BACK_STAGES-2:0]     v_r;
  logic                       out_valid_r;
  refv_item_t                 item_a_r;
  logic                       tr_a_r, tr_b_r, tr_c_r, tr_out_r;
  logic signed [M_W-1:0]      m_r, m_nxt;
  logic signed [2*IN_W:0]     pe_r [3];
  logic signed [2*IN_W:0]     pe_nxt [3];
  logic signed [IN_W+M_W-1:0] pn_r [3];
  logic signed [IN_W+M_W-1:0] pn_nxt [3];
  logic signed [R_W-1:0]      a_r [3];
  logic signed [R_W-1:0]      a_nxt [3];
  logic signed [R_W-1:0]      b_r [3];
  logic signed [R_W-1:0]      b_nxt [3];
  logic signed [OUT_W-1:0]    res_r [3];
  logic signed [OUT_W-1:0]    res_nxt [3];
  logic                       sat_r, sat_nxt;
  logic signed [IN_W-1:0]     iv [3];
  logic signed [IN_W-1:0]     nv [3];
  logic signed [R_W-1:0]      diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v_r         <= {v_r[BACK_STAGES-3:0], root_valid};
      out_valid_r <= v_r[BACK_STAGES-2];
    end
  end

  always_comb begin
    m_nxt = M_W'(root.ed) + M_W'($signed({1'b0, root.s}));
    iv[0] = item_a_r.ix;
    iv[1] = item_a_r.iy;
    iv[2] = item_a_r.iz;
    nv[0] = item_a_r.nx;
    nv[1] = item_a_r.ny;
    nv[2] = item_a_r.nz;
    sat_nxt = 1'b0;
    diff    = '0;
    for (int j = 0; j < 3; j++) begin
      pe_nxt[j] = $signed({1'b0, item_a_r.eta}) * iv[j];
      pn_nxt[j] = nv[j] * m_r;
      a_nxt[j]  = R_W'(rnd_frac(RND_W'(pe_r[j])));
      b_nxt[j]  = R_W'(rnd_frac(RND_W'(pn_r[j])));
      diff      = a_r[j] - b_r[j];
      if (tr_c_r) begin
        res_nxt[j] = '0;
      end else if (diff > R_W'(OUT_MAX)) begin
        res_nxt[j] = OUT_MAX;
        sat_nxt    = 1'b1;
      end else if (diff < R_W'(OUT_MIN)) begin
        res_nxt[j] = OUT_MIN;
        sat_nxt    = 1'b1;
      end else begin
        res_nxt[j] = OUT_W'(diff);
      end
    end
  end

  always_ff @(posedge clk) begin
    item_a_r <= root.item;
    tr_a_r   <= root.tr;
    m_r      <= m_nxt;
    tr_b_r   <= tr_a_r;
    pe_r     <= pe_nxt;
    pn_r     <= pn_nxt;
    tr_c_r   <= tr_b_r;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    tr_out_r <= tr_c_r;
    res_r    <= res_nxt;
    sat_r    <= sat_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_x     = res_r[0];
  assign out_y     = res_r[1];
  assign out_z     = res_r[2];
  assign out_tr    = tr_out_r;
  assign out_sat   = sat_r;

endmodule

@@ rtl/refract_vector_3d_unit.sv @@
// Refraction unit top level: eta i - n (eta d + sqrt(k)), Q x.14 fixed point
// Data flows through the front, square root and back pipelines, in that order.
// Throughput: one transaction per cycle outside reset; the 20-stage square root pipeline sets depth.
// Reset: synchronous active-low rst_n clears all valid bits; busy is high during reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
module refract_vector_3d_unit import refv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [IN_W-1:0]  in_incident_x,
  input  logic signed [IN_W-1:0]  in_incident_y,
  input  logic signed [IN_W-1:0]  in_incident_z,
  input  logic signed [IN_W-1:0]  in_normal_x,
  input  logic signed [IN_W-1:0]  in_normal_y,
  input  logic signed [IN_W-1:0]  in_normal_z,
  input  logic [IN_W-1:0]         in_index_ratio,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_refracted_x,
  output logic signed [OUT_W-1:0] out_refracted_y,
  output logic signed [OUT_W-1:0] out_refracted_z,
  output logic                    out_total_reflection,
  output logic                    out_saturated
);

  refv_item_t in_item;
  refv_mid_t  mid;
  refv_root_t root;
  logic       in_valid, mid_valid, root_valid;

  assign busy      = ~rst_n;
  assign in_valid  = start & ~busy;

  assign in_item.ix  = in_incident_x;
  assign in_item.iy  = in_incident_y;
  assign in_item.iz  = in_incident_z;
  assign in_item.nx  = in_normal_x;
  assign in_item.ny  = in_normal_y;
  assign in_item.nz  = in_normal_z;
  assign in_item.eta = in_index_ratio;

  refv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .mid_valid (mid_valid),
    .mid       (mid)
  );

  refv_sqrt u_sqrt (
    .clk        (clk),
    .rst_n      (rst_n),
    .mid_valid  (mid_valid),
    .mid        (mid),
    .root_valid (root_valid),
    .root       (root)
  );

  refv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .root_valid (root_valid),
    .root       (root),
    .out_valid  (out_valid),
    .out_x      (out_refracted_x),
    .out_y      (out_refracted_y),
    .out_z      (out_refracted_z),
    .out_tr     (out_total_reflection),
    .out_sat    (out_saturated)
  );

endmodule

@@ rtl/refv_chk.sv @@
// Port-level checker for the refraction unit, bound to the top level
`include "refract_vector_3d_unit_assert.svh"

module refv_chk import refv_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic signed [IN_W-1:0]  in_incident_x,
  input logic signed [IN_W-1:0]  in_incident_y,
  input logic signed [IN_W-1:0]  in_incident_z,
  input logic signed [IN_W-1:0]  in_normal_x,
  input logic signed [IN_W-1:0]  in_normal_y,
  input logic signed [IN_W-1:0]  in_normal_z,
  input logic [IN_W-1:0]         in_index_ratio,
  input logic                    out_valid,
  input logic signed [OUT_W-1:0] out_refracted_x,
  input logic signed [OUT_W-1:0] out_refracted_y,
  input logic signed [OUT_W-1:0] out_refracted_z,
  input logic                    out_total_reflection,
  input logic                    out_saturated
);

  localparam int CNT_W = $clog2(LATENCY + 1);

  // cycles since reset release, saturating at the pipeline depth
  logic [CNT_W-1:0] cnt_r;
  logic             warm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cnt_r != CNT_W'(LATENCY)) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign warm = (cnt_r == CNT_W'(LATENCY));

  `REFV_ASSERT_IMP(a_result_has_txn, clk, rst_n, out_valid && warm, $past(start && !busy, LATENCY))

  `REFV_ASSERT_NXT(a_txn_gives_result, clk, rst_n, warm && $past(start && !busy, LATENCY - 1), out_valid)

  `REFV_ASSERT_IMP(a_reflect_zero, clk, rst_n, out_valid && out_total_reflection, out_refracted_x == '0 && out_refracted_y == '0 && out_refracted_z == '0 && !out_saturated)

  // eta of zero gives k of one and a result of minus the normal
  `REFV_ASSERT_IMP(a_eta_zero, clk, rst_n, out_valid && warm && $past(in_index_ratio, LATENCY) == '0, !out_total_reflection && !out_saturated && out_refracted_x == -OUT_W'($past(in_normal_x, LATENCY)) && out_refracted_y == -OUT_W'($past(in_normal_y, LATENCY)) && out_refracted_z == -OUT_W'($past(in_normal_z, LATENCY)))

endmodule

bind refract_vector_3d_unit refv_chk u_refv_chk (.*);

@@ bench/tb_refract_vector_3d_unit.sv @@
// Self-checking testbench for refract_vector_3d_unit: directed and random refraction items
`timescale 1ns / 100ps

module tb_refract_vector_3d_unit import refv_pkg::*; ();

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1250;

  typedef struct packed {
    logic signed [OUT_W-1:0] rx;
    logic signed [OUT_W-1:0] ry;
    logic signed [OUT_W-1:0] rz;
    logic                    total_refl;
    logic                    sat;
  } refraction_t;

  class refract_scoreboard;
    refraction_t refracted_expected_q[$];
    int errors;

    function longint round_frac(longint x);
      longint mag;
      mag = (x < 0) ? -x : x;
      mag = (mag + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      return (x < 0) ? -mag : mag;
    endfunction

    // floor(sqrt(x)), built one result bit at a time
    function longint floor_sqrt(longint unsigned x);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= x) root = trial;
      end
      return longint'(root);
    endfunction

    function longint clamp_out(longint r, ref logic sat);
      if (r > longint'(OUT_MAX)) begin
        sat = 1'b1;
        return longint'(OUT_MAX);
      end
      if (r < longint'(OUT_MIN)) begin
        sat = 1'b1;
        return longint'(OUT_MIN);
      end
      return r;
    endfunction

    function refraction_t refract_predict(refv_item_t it);
      refraction_t res;
      longint q_one, eta, dot, d, dd, e2, k, s, m;
      logic sat;
      q_one = longint'(1) <<< FRAC_BITS;
      eta = longint'({48'd0, it.eta});
      dot = longint'(it.nx) * longint'(it.ix) + longint'(it.ny) * longint'(it.iy)
          + longint'(it.nz) * longint'(it.iz);
      d = round_frac(dot);
      dd = round_frac(d * d);
      e2 = round_frac(eta * eta);
      k = q_one - round_frac(e2 * (q_one - dd));
      res = '0;
      if (k < 0) begin
        res.total_refl = 1'b1;
        return res;
      end
      s = floor_sqrt(longint'(k) <<< FRAC_BITS);
      m = round_frac(eta * d) + s;
      sat = 1'b0;
      res.rx = OUT_W'(clamp_out(round_frac(eta * it.ix) - round_frac(it.nx * m), sat));
      res.ry = OUT_W'(clamp_out(round_frac(eta * it.iy) - round_frac(it.ny * m), sat));
      res.rz = OUT_W'(clamp_out(round_frac(eta * it.iz) - round_frac(it.nz * m), sat));
      res.sat = sat;
      return res;
    endfunction

    function void note_item(refv_item_t it);
      refracted_expected_q.push_back(refract_predict(it));
    endfunction

    function void check_result(refraction_t got);
      refraction_t exp_r;
      if (refracted_expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected result x=%0d y=%0d z=%0d tr=%0b sat=%0b",
                   got.rx, got.ry, got.rz, got.total_refl, got.sat);
        return;
      end
      exp_r = refracted_expected_q.pop_front();
      if (got.rx !== exp_r.rx || got.ry !== exp_r.ry || got.rz !== exp_r.rz ||
          got.total_refl !== exp_r.total_refl || got.sat !== exp_r.sat) begin
        errors++;
        if (errors <= 10)
          $display({"ERROR: exp x=%0d y=%0d z=%0d tr=%0b sat=%0b, ",
                    "got x=%0d y=%0d z=%0d tr=%0b sat=%0b"},
                   exp_r.rx, exp_r.ry, exp_r.rz, exp_r.total_refl, exp_r.sat,
                   got.rx, got.ry, got.rz, got.total_refl, got.sat);
      end
    endfunction

    function int pending();
      return refracted_expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  refv_item_t drv_item;
  logic out_valid;
  logic signed [OUT_W-1:0] out_refracted_x;
  logic signed [OUT_W-1:0] out_refracted_y;
  logic signed [OUT_W-1:0] out_refracted_z;
  logic out_total_reflection;
  logic out_saturated;
  int cycle_count;

  refract_scoreboard sb = new();

  refract_vector_3d_unit u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_incident_x        (drv_item.ix),
    .in_incident_y        (drv_item.iy),
    .in_incident_z        (drv_item.iz),
    .in_normal_x          (drv_item.nx),
    .in_normal_y          (drv_item.ny),
    .in_normal_z          (drv_item.nz),
    .in_index_ratio       (drv_item.eta),
    .out_valid            (out_valid),
    .out_refracted_x      (out_refracted_x),
    .out_refracted_y      (out_refracted_y),
    .out_refracted_z      (out_refracted_z),
    .out_total_reflection (out_total_reflection),
    .out_saturated        (out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_item(drv_item);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result('{out_refracted_x, out_refracted_y, out_refracted_z,
                        out_total_reflection, out_saturated});
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL refract_vector_3d_unit");
    $finish;
  end

  task automatic send_item(input refv_item_t it, input bit allow_idle);
    while (allow_idle && $urandom_range(0, 99) < 13) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    drv_item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_vec(input logic [15:0] ix, iy, iz, nx, ny, nz, eta);
    refv_item_t it;
    it.ix = ix;
    it.iy = iy;
    it.iz = iz;
    it.nx = nx;
    it.ny = ny;
    it.nz = nz;
    it.eta = eta;
    send_item(it, 1'b0);
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // random direction scaled to about unit length in Q1.14
  task automatic unit_dir(output logic signed [15:0] a, b, c);
    real va, vb, vc, len;
    va = real'(int'($urandom_range(0, 65535)) - 32768);
    vb = real'(int'($urandom_range(0, 65535)) - 32768);
    vc = real'(int'($urandom_range(0, 65535)) - 32768);
    len = $sqrt(va * va + vb * vb + vc * vc);
    if (len < 1.0) begin
      va = 1.0;
      len = 1.0;
    end
    a = 16'($rtoi(va * 16383.0 / len));
    b = 16'($rtoi(vb * 16383.0 / len));
    c = 16'($rtoi(vc * 16383.0 / len));
  endtask

  function automatic refv_item_t random_raw();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(refv_item_t)-1:0];
  endfunction

  initial begin
    refv_item_t it;
    int mode;
    rst_n = 1'b0;
    start = 1'b0;
    drv_item = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_vec(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_vec(16'h0000, 16'h0000, 16'hc000, 16'h0000, 16'h0000, 16'h4000, 16'h4000);
    // eta 2 with the incident perpendicular to the normal: total reflection
    send_vec(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h8000);
    // eta 1 with d = 0 puts k exactly at zero
    send_vec(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h4000);
    send_vec(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff);
    send_vec(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hffff);
    send_vec(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'hffff);
    send_vec(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h0000);
    send_vec(16'h7fff, 16'h8000, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'hffff);
    send_vec(16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h0001);
    send_vec(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h4000);
    send_vec(16'h1234, 16'hedcb, 16'h5555, 16'haaaa, 16'h0f0f, 16'hf0f0, 16'h0000);
    send_vec(16'h2d41, 16'h0000, 16'hd2bf, 16'h0000, 16'h0000, 16'h4000, 16'h6000);
    send_vec(16'h2d41, 16'h0000, 16'hd2bf, 16'h0000, 16'h0000, 16'h4000, 16'h2aab);
    send_vec(16'h2d41, 16'h0000, 16'hd2bf, 16'h0000, 16'h0000, 16'h4000, 16'h5555);
    send_vec(16'h0001, 16'hffff, 16'h0001, 16'hffff, 16'h0001, 16'hffff, 16'h8000);
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 900) drain_results();
      mode = $urandom_range(0, 99);
      if (mode < 75) begin
        unit_dir(it.ix, it.iy, it.iz);
        unit_dir(it.nx, it.ny, it.nz);
        it.eta = (mode < 60) ? 16'($urandom_range(4096, 40000)) : 16'($urandom);
      end else begin
        it = random_raw();
      end
      send_item(it, !(n >= 300 && n < 600));
    end
    drain_results();
    repeat (LATENCY + 8) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS refract_vector_3d_unit");
    end else begin
      $display("FAIL refract_vector_3d_unit");
    end
    $finish;
  end

endmodule
